// ===== sv/gbgd_pkg.sv =====
// Shared constants, codes and tables of the Gaussian bias grid deposit block.
package gbgd_pkg;

    // Default geometry of the grid.
    localparam int POINTS_PER_AXIS_DEF = 64;
    localparam int NUM_AXES_DEF        = 2;

    // Word layout of the streams.
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Action codes carried in tuser.
    localparam logic [1:0] ACT_DEPOSIT = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_WRITE   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_HEIGHT    = 3'd0;
    localparam logic [2:0] REG_INV_WIDTH = 3'd1;
    localparam logic [2:0] REG_PERIODIC  = 3'd2;
    localparam logic [2:0] REG_ORIGIN0   = 3'd3;
    localparam logic [2:0] REG_ORIGIN1   = 3'd4;
    localparam logic [2:0] REG_STEP0     = 3'd5;
    localparam logic [2:0] REG_STEP1     = 3'd6;

    // Fixed-point constants: pi in Q.12, log2(e) in Q.16, exponent argument cap.
    localparam logic [29:0] PI_Q12     = 30'd12868;
    localparam logic [29:0] TWO_PI_Q12 = 30'd25736;
    localparam logic [16:0] LOG2E_Q16  = 17'd94548;
    localparam logic [24:0] ARG_CAP    = 25'd16777216;
    localparam logic [32:0] INT32_TOP  = 33'h0_7FFF_FFFF;

    // Table of 2^(-i/16) in Q1.16, i from 0 to 16.
    function automatic logic [16:0] pow2_frac(input logic [4:0] idx);
        logic [16:0] val;
        unique case (idx)
            5'd0:    val = 17'd65536;
            5'd1:    val = 17'd62757;
            5'd2:    val = 17'd60097;
            5'd3:    val = 17'd57549;
            5'd4:    val = 17'd55109;
            5'd5:    val = 17'd52773;
            5'd6:    val = 17'd50535;
            5'd7:    val = 17'd48393;
            5'd8:    val = 17'd46341;
            5'd9:    val = 17'd44376;
            5'd10:   val = 17'd42495;
            5'd11:   val = 17'd40693;
            5'd12:   val = 17'd38968;
            5'd13:   val = 17'd37316;
            5'd14:   val = 17'd35734;
            5'd15:   val = 17'd34219;
            default: val = 17'd32768;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/gaussian_bias_grid_deposit.sv =====
// Top level: bias grid over two collective variables with Gaussian deposit.
// A deposit word visits every lattice point in turn, each through states stepped by the
// sequencer on one shared 25x24 multiplier; a read goes through an address and a data state,
// a write or an unknown action is answered from idle. One word is in work at a time.
// Reset (aresetn low, synchronous) loads register defaults, then a clearing pass zeroes
// all POINTS_PER_AXIS*POINTS_PER_AXIS entries of the store before words are taken.
module gaussian_bias_grid_deposit #(
    parameter int POINTS_PER_AXIS = gbgd_pkg::POINTS_PER_AXIS_DEF,
    parameter int NUM_AXES        = gbgd_pkg::NUM_AXES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gbgd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gbgd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_axis0[19:0], pos_axis1[39:20], entry_index[51:40], entry_value[83:52], zeros
    input  logic [gbgd_pkg::IN_TDATA_W-1:0]    s_tdata,
    // action[1:0]
    input  logic [1:0]                         s_tuser,
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // bias_value[31:0], saturated[32], zeros
    output logic [gbgd_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // done_action[1:0]
    output logic [1:0]                         m_tuser
);
    import gbgd_pkg::*;

    localparam int DEPTH       = POINTS_PER_AXIS * POINTS_PER_AXIS;
    localparam int GRID_POINTS = (NUM_AXES >= 2) ? DEPTH : POINTS_PER_AXIS;
    localparam int AW          = $clog2(DEPTH);
    localparam int IW          = $clog2(POINTS_PER_AXIS);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD_ADDR, ST_RD_DATA,
        ST_LAT, ST_DIF, ST_SQ, ST_DSUM,
        ST_WLO, ST_WHI, ST_ARG, ST_E0, ST_E1, ST_E2, ST_H, ST_ACC
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [23:0]        height_reg;
    logic [15:0]        inv_width_reg;
    logic [1:0]         periodic_reg;
    logic signed [19:0] origin0_reg, origin1_reg;
    logic [18:0]        step0_reg, step1_reg;

    // Word being worked on.
    logic signed [19:0] pos0_reg, pos1_reg;
    logic [11:0]        idx_reg;
    logic               idx_ok_reg;

    // Sweep counters and datapath registers.
    logic [AW-1:0]  f_reg;
    logic [IW-1:0]  i0_reg, i1_reg;
    logic           axis_reg;
    logic           big_reg;
    logic [21:0]    dq_reg;
    logic [44:0]    dist_reg;
    logic [35:0]    lo_reg;
    logic [24:0]    arg_reg;
    logic [9:0]     k_reg;
    logic [16:0]    ti_reg;
    logic [16:0]    e_reg;
    logic [48:0]    prod_reg;

    // Result registers.
    logic        m_tvalid_reg;
    logic [31:0] bias_reg;
    logic [1:0]  act_reg;
    logic        sat_reg;

    // Store ports.
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    // Input word fields.
    logic               in_accept;
    logic [1:0]         in_action;
    logic signed [19:0] in_pos0, in_pos1;
    logic [11:0]        in_idx;
    logic [31:0]        in_value;
    logic               in_ok;

    assign in_accept = s_tvalid && s_tready;
    assign in_action = s_tuser;
    assign in_pos0   = s_tdata[19:0];
    assign in_pos1   = s_tdata[39:20];
    assign in_idx    = s_tdata[51:40];
    assign in_value  = s_tdata[83:52];
    assign in_ok     = ({20'd0, in_idx} < 32'(GRID_POINTS));

    assign s_tready  = (state_reg == ST_IDLE) && !m_tvalid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {7'd0, sat_reg, bias_reg};
    assign m_tuser   = act_reg;

    // Shared multiplier: operand selection by state, product registered.
    logic [24:0] mul_a;
    logic [23:0] mul_b;
    logic [25:0] t_val;
    logic [3:0]  t_i;
    logic [16:0] t_hi, t_lo;

    assign t_val = prod_reg[41:16];
    assign t_i   = t_val[15:12];
    assign t_hi  = pow2_frac({1'b0, t_i});
    assign t_lo  = pow2_frac(5'({1'b0, t_i}) + 5'd1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LAT: begin
                mul_a = 25'(axis_reg ? i1_reg : i0_reg);
                mul_b = 24'(axis_reg ? step1_reg : step0_reg);
            end
            ST_SQ: begin
                mul_a = 25'(dq_reg);
                mul_b = 24'(dq_reg);
            end
            ST_WLO: begin
                mul_a = 25'(dist_reg[19:0]);
                mul_b = 24'(inv_width_reg);
            end
            ST_WHI: begin
                mul_a = 25'(dist_reg[39:20]);
                mul_b = 24'(inv_width_reg);
            end
            ST_E0: begin
                mul_a = arg_reg;
                mul_b = 24'(LOG2E_Q16);
            end
            ST_E1: begin
                mul_a = 25'(t_hi - t_lo);
                mul_b = 24'(t_val[11:0]);
            end
            ST_H: begin
                mul_a = 25'(height_reg);
                mul_b = 24'(e_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Distance along the current axis, wrapped on a periodic axis.
    logic signed [29:0] lat, d_diff, d_per;
    logic [29:0]        d_abs, d_mag;

    always_comb begin
        lat    = (axis_reg ? 30'(origin1_reg) : 30'(origin0_reg))
               + signed'({1'b0, prod_reg[28:0]});
        d_diff = (axis_reg ? 30'(pos1_reg) : 30'(pos0_reg)) - lat;
        d_abs  = (d_diff < 0) ? 30'(-d_diff) : 30'(d_diff);
        if (periodic_reg[axis_reg] && (d_abs >= PI_Q12)) begin
            d_per = signed'(d_abs) - signed'(TWO_PI_Q12);
        end else begin
            d_per = signed'(d_abs);
        end
        d_mag  = (d_per < 0) ? 30'(-d_per) : 30'(d_per);
    end

    // Exponent argument from the split product, capped.
    logic [55:0] arg_full;
    logic [24:0] arg_val;

    always_comb begin
        arg_full = {prod_reg[35:0], 20'd0} + 56'(lo_reg);
        if (inv_width_reg == 16'd0) begin
            arg_val = '0;
        end else if (big_reg || (dist_reg[44:40] != 5'd0)
                     || (arg_full[55:16] > 40'(ARG_CAP))) begin
            arg_val = ARG_CAP;
        end else begin
            arg_val = arg_full[40:16];
        end
    end

    // Interpolated fraction and rounded power-of-two shift.
    logic [12:0] drop;
    logic [16:0] v_frac;
    logic [17:0] half, e_val;

    always_comb begin
        drop   = 13'((25'(prod_reg[23:0]) + 25'd2048) >> 12);
        v_frac = ti_reg - 17'(drop);
        half   = (k_reg == 10'd0) ? 18'd0 : (18'd1 << (k_reg[4:0] - 5'd1));
        e_val  = (k_reg > 10'd16) ? 18'd0 : ((18'(v_frac) + half) >> k_reg[4:0]);
    end

    // Saturating accumulation into the entry.
    logic [24:0]        add_val;
    logic signed [32:0] sum_val;
    logic               sum_sat;
    logic [31:0]        sum_out;

    always_comb begin
        add_val = 25'((42'(prod_reg[40:0]) + 42'd32768) >> 16);
        sum_val = 33'(signed'(mem_rdata)) + signed'({8'd0, add_val});
        sum_sat = (sum_val > signed'(INT32_TOP));
        sum_out = sum_sat ? INT32_TOP[31:0] : sum_val[31:0];
    end

    // Store port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = f_reg;
        mem_wdata = '0;
        mem_raddr = f_reg;
        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                mem_we    = in_accept && (in_action == ACT_WRITE) && in_ok;
                mem_waddr = AW'(in_idx);
                mem_wdata = in_value;
            end
            ST_RD_ADDR: begin
                mem_raddr = AW'(idx_reg);
            end
            ST_ACC: begin
                mem_we    = 1'b1;
                mem_wdata = sum_out;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    gbgd_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg    <= 24'd65536;
            inv_width_reg <= 16'd256;
            periodic_reg  <= '0;
            origin0_reg   <= '0;
            origin1_reg   <= '0;
            step0_reg     <= 19'd4096;
            step1_reg     <= 19'd4096;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HEIGHT:    height_reg    <= cfg_data;
                REG_INV_WIDTH: inv_width_reg <= cfg_data[15:0];
                REG_PERIODIC:  periodic_reg  <= cfg_data[1:0];
                REG_ORIGIN0:   origin0_reg   <= cfg_data[19:0];
                REG_ORIGIN1:   origin1_reg   <= cfg_data[19:0];
                REG_STEP0:     step0_reg     <= cfg_data[18:0];
                REG_STEP1:     step1_reg     <= cfg_data[18:0];
                default:       height_reg    <= height_reg;
            endcase
        end
    end

    // Sequencer with datapath and result registers.
    always_ff @(posedge aclk) begin
        prod_reg <= 49'(mul_a) * 49'(mul_b);
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            f_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    f_reg <= f_reg + 1'b1;
                    if (f_reg == AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        pos0_reg   <= in_pos0;
                        pos1_reg   <= in_pos1;
                        idx_reg    <= in_idx;
                        idx_ok_reg <= in_ok;
                        act_reg    <= in_action;
                        bias_reg   <= '0;
                        sat_reg    <= 1'b0;
                        f_reg      <= '0;
                        i0_reg     <= '0;
                        i1_reg     <= '0;
                        axis_reg   <= 1'b0;
                        big_reg    <= 1'b0;
                        dist_reg   <= '0;
                        if (in_action == ACT_DEPOSIT) begin
                            state_reg <= ST_LAT;
                        end else if (in_action == ACT_READ) begin
                            state_reg <= ST_RD_ADDR;
                        end else begin
                            m_tvalid_reg <= 1'b1;
                        end
                    end
                end
                ST_RD_ADDR: begin
                    state_reg <= ST_RD_DATA;
                end
                ST_RD_DATA: begin
                    bias_reg     <= idx_ok_reg ? mem_rdata : 32'd0;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= ST_IDLE;
                end
                ST_LAT: begin
                    state_reg <= ST_DIF;
                end
                ST_DIF: begin
                    dq_reg    <= d_mag[21:0];
                    big_reg   <= big_reg || (d_mag[29:22] != 8'd0);
                    state_reg <= ST_SQ;
                end
                ST_SQ: begin
                    state_reg <= ST_DSUM;
                end
                ST_DSUM: begin
                    dist_reg <= dist_reg + 45'(prod_reg[43:0]);
                    if (axis_reg == 1'(NUM_AXES - 1)) begin
                        state_reg <= ST_WLO;
                    end else begin
                        axis_reg  <= 1'b1;
                        state_reg <= ST_LAT;
                    end
                end
                ST_WLO: begin
                    state_reg <= ST_WHI;
                end
                ST_WHI: begin
                    lo_reg    <= prod_reg[35:0];
                    state_reg <= ST_ARG;
                end
                ST_ARG: begin
                    arg_reg   <= arg_val;
                    state_reg <= ST_E0;
                end
                ST_E0: begin
                    state_reg <= ST_E1;
                end
                ST_E1: begin
                    k_reg     <= t_val[25:16];
                    ti_reg    <= t_hi;
                    state_reg <= ST_E2;
                end
                ST_E2: begin
                    e_reg     <= e_val[16:0];
                    state_reg <= ST_H;
                end
                ST_H: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    sat_reg  <= sat_reg || sum_sat;
                    axis_reg <= 1'b0;
                    big_reg  <= 1'b0;
                    dist_reg <= '0;
                    f_reg    <= f_reg + 1'b1;
                    if (NUM_AXES >= 2) begin
                        if (i1_reg == IW'(POINTS_PER_AXIS - 1)) begin
                            i1_reg <= '0;
                            i0_reg <= i0_reg + 1'b1;
                        end else begin
                            i1_reg <= i1_reg + 1'b1;
                        end
                    end else begin
                        i0_reg <= i0_reg + 1'b1;
                    end
                    if (f_reg == AW'(GRID_POINTS - 1)) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end else begin
                        state_reg <= ST_LAT;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A new word is taken only when no result waits.
    a_accept_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> !m_tvalid_reg)
        else $error("word accepted while a result is pending");

    // No result appears while the store is being cleared.
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_tvalid_reg)
        else $error("result raised during the clearing pass");

    // The store is written only when clearing, writing or finishing an entry.
    a_store_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE || state_reg == ST_ACC))
        else $error("store written outside a write step");

    // A deposit result follows the last entry update.
    a_deposit_end: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid_reg) && (act_reg == ACT_DEPOSIT)) |-> $past(state_reg == ST_ACC))
        else $error("deposit result without a finished sweep");

endmodule

// ===== sv/gbgd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
